// File: sv/h3d_pkg.sv
// shared types, constants and step functions for the 3d hilbert index to coordinate unit
`default_nettype none

package h3d_pkg;

    localparam int IDX_W         = 30;
    localparam int COORD_W       = 10;
    localparam int CFG_W         = 4;
    localparam int MAX_ORDER_DEF = 10;
    localparam logic [CFG_W-1:0] ORDER_RESET = 4'd8;

    // axis codes
    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    // a basis vector is always a signed unit vector on one axis
    typedef struct packed {
        logic [1:0] axis;
        logic       neg;
    } basis_vec_t;

    typedef struct packed {
        basis_vec_t a;
        basis_vec_t b;
        basis_vec_t c;
    } basis_t;

    localparam basis_t BASIS_INIT = '{
        a: '{axis: AXIS_X, neg: 1'b0},
        b: '{axis: AXIS_Y, neg: 1'b0},
        c: '{axis: AXIS_Z, neg: 1'b0}
    };

    // sub-cube offset weights {ua, ub, uc} per octant digit
    function automatic logic [2:0] digit_weights(input logic [2:0] digit);
        logic [2:0] w;
        case (digit)
            3'd0:    w = 3'b000;
            3'd1:    w = 3'b100;
            3'd2:    w = 3'b110;
            3'd3:    w = 3'b010;
            3'd4:    w = 3'b011;
            3'd5:    w = 3'b111;
            3'd6:    w = 3'b101;
            3'd7:    w = 3'b001;
            default: w = 3'b000;
        endcase
        return w;
    endfunction

    function automatic basis_vec_t flip(input basis_vec_t v);
        basis_vec_t r;
        r     = v;
        r.neg = ~v.neg;
        return r;
    endfunction

    // basis permutation and negation for the next level
    function automatic basis_t next_basis(input basis_t cur, input logic [2:0] digit);
        basis_t nb;
        case (digit)
            3'd0:    nb = '{a: cur.b,       b: cur.c,       c: cur.a};
            3'd1,
            3'd2:    nb = '{a: cur.c,       b: cur.a,       c: cur.b};
            3'd3,
            3'd4:    nb = '{a: flip(cur.a), b: flip(cur.b), c: cur.c};
            3'd5,
            3'd6:    nb = '{a: flip(cur.c), b: cur.a,       c: flip(cur.b)};
            3'd7:    nb = '{a: cur.b,       b: flip(cur.c), c: flip(cur.a)};
            default: nb = cur;
        endcase
        return nb;
    endfunction

    // coordinate bit per axis for this level: corner shift plus offset,
    // which collapses to weight xor sign of the vector on that axis
    function automatic logic [2:0] level_bits(input basis_t cur, input logic [2:0] w);
        logic [2:0] bits;
        bits = 3'b000;
        bits[cur.a.axis] = w[2] ^ cur.a.neg;
        bits[cur.b.axis] = w[1] ^ cur.b.neg;
        bits[cur.c.axis] = w[0] ^ cur.c.neg;
        return bits;
    endfunction

endpackage

`default_nettype wire

// File: sv/hilbert3d_index_to_coord_unit.sv
// top level: maps a 3d hilbert curve position to x, y, z lattice coordinates
//
//  channel   direction  signals                                  transaction
//  command   in         start, busy, curve_index                 start high while busy low
//  result    out        done, coord_x, coord_y, coord_z,         done high for one cycle
//                       out_of_range
//  config    in         cfg_wr_en, cfg_wr_data                   cfg_wr_en high at the edge
//
//  levels: a position with order n >= 1 in range walks n levels, one curve level per cycle
//  in the shared level step unit; done shows in the cycle after the last level
//  out of range positions and order zero report done in the cycle right after acceptance
//  busy is high only while levels run; a new start is taken in the same cycle done shows
//  reset: async active low, returns to idle with curve_order = 8
//  the receiver cannot stall; done marks each result for exactly one cycle, the ports hold it until the next
`default_nettype none

module hilbert3d_index_to_coord_unit #(
    parameter int MAX_ORDER = h3d_pkg::MAX_ORDER_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    // command transaction
    input  wire logic                        start,
    output logic                             busy,
    input  wire logic [h3d_pkg::IDX_W-1:0]   curve_index,
    // configuration write
    input  wire logic                        cfg_wr_en,
    input  wire logic [h3d_pkg::CFG_W-1:0]   cfg_wr_data,
    // result transaction
    output logic                             done,
    output logic [h3d_pkg::COORD_W-1:0]      coord_x,
    output logic [h3d_pkg::COORD_W-1:0]      coord_y,
    output logic [h3d_pkg::COORD_W-1:0]      coord_z,
    output logic                             out_of_range
);

    // level counter wide enough to hold MAX_ORDER itself
    localparam int LVL_W = $clog2(MAX_ORDER + 1);
    // digit table padded to a power of two so the counter indexes it exactly
    localparam int DIG_N = 1 << LVL_W;
    localparam int EXT_W = (3 * DIG_N > h3d_pkg::IDX_W) ? 3 * DIG_N : h3d_pkg::IDX_W;
    // coordinates carry one bit per level
    localparam int POS_W = MAX_ORDER;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } state_t;

    state_t                         state_reg, state_next;
    logic [h3d_pkg::CFG_W-1:0]      order_cfg_reg, order_cfg_next;
    logic [h3d_pkg::IDX_W-1:0]      idx_reg, idx_next;
    logic [LVL_W-1:0]               lvl_reg, lvl_next;
    h3d_pkg::basis_t                basis_reg, basis_next;
    logic [POS_W-1:0]               pos_x_reg, pos_x_next;
    logic [POS_W-1:0]               pos_y_reg, pos_y_next;
    logic [POS_W-1:0]               pos_z_reg, pos_z_next;
    logic                           done_reg, done_next;
    logic                           oor_reg, oor_next;
    logic [h3d_pkg::COORD_W-1:0]    coord_x_reg, coord_x_next;
    logic [h3d_pkg::COORD_W-1:0]    coord_y_reg, coord_y_next;
    logic [h3d_pkg::COORD_W-1:0]    coord_z_reg, coord_z_next;

    logic                           accept;
    logic [LVL_W-1:0]               sat_order;
    logic                           range_hit;
    logic [EXT_W-1:0]               idx_ext;
    logic [2:0]                     digit_arr [DIG_N];
    logic [2:0]                     cur_digit;
    logic [2:0]                     cur_weights;
    logic [2:0]                     cur_bits;

    assign accept = start && (state_reg == ST_IDLE);

    // order saturates at the build limit
    always_comb
    begin
        if (int'(order_cfg_reg) > MAX_ORDER)
        begin
            sat_order = LVL_W'(MAX_ORDER);
        end
        else
        begin
            sat_order = LVL_W'(order_cfg_reg);
        end
    end

    // any index bit at or above 3 * order means the position is off the curve
    always_comb
    begin
        range_hit = 1'b0;
        for (int j = 0; j < h3d_pkg::IDX_W; j++)
        begin
            if (curve_index[j] && (j >= 3 * int'(sat_order)))
            begin
                range_hit = 1'b1;
            end
        end
    end

    // octant digits, lowest level first
    always_comb
    begin
        idx_ext = EXT_W'(idx_reg);
        for (int i = 0; i < DIG_N; i++)
        begin
            digit_arr[i] = idx_ext[3*i +: 3];
        end
    end

    // shared level step: one octant digit per cycle
    assign cur_digit   = digit_arr[lvl_reg];
    assign cur_weights = h3d_pkg::digit_weights(cur_digit);
    assign cur_bits    = h3d_pkg::level_bits(basis_reg, cur_weights);

    always_comb
    begin
        state_next     = state_reg;
        order_cfg_next = order_cfg_reg;
        idx_next       = idx_reg;
        lvl_next       = lvl_reg;
        basis_next     = basis_reg;
        pos_x_next     = pos_x_reg;
        pos_y_next     = pos_y_reg;
        pos_z_next     = pos_z_reg;
        done_next      = 1'b0;
        oor_next       = oor_reg;
        coord_x_next   = coord_x_reg;
        coord_y_next   = coord_y_reg;
        coord_z_next   = coord_z_reg;

        if (cfg_wr_en)
        begin
            order_cfg_next = cfg_wr_data;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (range_hit || (sat_order == '0))
                    begin
                        // no levels to walk: answer right away
                        done_next    = 1'b1;
                        oor_next     = range_hit;
                        coord_x_next = '0;
                        coord_y_next = '0;
                        coord_z_next = '0;
                    end
                    else
                    begin
                        state_next = ST_RUN;
                        idx_next   = curve_index;
                        lvl_next   = sat_order - 1'b1;
                        basis_next = h3d_pkg::BASIS_INIT;
                        pos_x_next = '0;
                        pos_y_next = '0;
                        pos_z_next = '0;
                    end
                end
            end
            ST_RUN:
            begin
                // levels run top down, so each new bit shifts in at the bottom
                pos_x_next = POS_W'({pos_x_reg, cur_bits[0]});
                pos_y_next = POS_W'({pos_y_reg, cur_bits[1]});
                pos_z_next = POS_W'({pos_z_reg, cur_bits[2]});
                basis_next = h3d_pkg::next_basis(basis_reg, cur_digit);
                if (lvl_reg == '0)
                begin
                    state_next   = ST_IDLE;
                    done_next    = 1'b1;
                    oor_next     = 1'b0;
                    coord_x_next = h3d_pkg::COORD_W'(pos_x_next);
                    coord_y_next = h3d_pkg::COORD_W'(pos_y_next);
                    coord_z_next = h3d_pkg::COORD_W'(pos_z_next);
                end
                else
                begin
                    lvl_next = lvl_reg - 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            order_cfg_reg <= h3d_pkg::ORDER_RESET;
            done_reg      <= 1'b0;
            oor_reg       <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            order_cfg_reg <= order_cfg_next;
            done_reg      <= done_next;
            oor_reg       <= oor_next;
        end
    end

    // datapath registers, no reset needed
    always_ff @(posedge clk)
    begin
        idx_reg     <= idx_next;
        lvl_reg     <= lvl_next;
        basis_reg   <= basis_next;
        pos_x_reg   <= pos_x_next;
        pos_y_reg   <= pos_y_next;
        pos_z_reg   <= pos_z_next;
        coord_x_reg <= coord_x_next;
        coord_y_reg <= coord_y_next;
        coord_z_reg <= coord_z_next;
    end

    assign busy         = (state_reg == ST_RUN);
    assign done         = done_reg;
    assign out_of_range = oor_reg;
    assign coord_x      = coord_x_reg;
    assign coord_y      = coord_y_reg;
    assign coord_z      = coord_z_reg;

    // level counter steps down by one while more levels remain
    a_lvl_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN && lvl_reg != '0)
        |=> (state_reg == ST_RUN && lvl_reg == $past(lvl_reg) - 1'b1))
        else $error("level counter did not step down");

    // last level always produces a result strobe
    a_last_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN && lvl_reg == '0) |=> (done_reg && !oor_reg))
        else $error("missing result after last level");

    // an in-range item with levels to walk starts the sequencer
    a_start_run: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !range_hit && sat_order != '0) |=> (state_reg == ST_RUN && !done_reg))
        else $error("accepted item did not enter level walk");

    // off-curve results carry zero coordinates
    a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && oor_reg)
        |-> (coord_x_reg == '0 && coord_y_reg == '0 && coord_z_reg == '0))
        else $error("out of range result with nonzero coordinates");

    // basis vectors stay on three distinct real axes while walking
    a_basis_perm: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN)
        |-> (basis_reg.a.axis != basis_reg.b.axis && basis_reg.b.axis != basis_reg.c.axis
             && basis_reg.a.axis != basis_reg.c.axis && basis_reg.a.axis != 2'd3
             && basis_reg.b.axis != 2'd3 && basis_reg.c.axis != 2'd3))
        else $error("basis is no longer a permutation");

endmodule

`default_nettype wire
